@@ rtl/core/mandelbrot_escape_time_assert.svh @@
// Assertion macros shared by the escape-time RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH

// same-cycle implication
`define MBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mandelbrot_escape_time: same-cycle check failed");

// next-cycle implication
`define MBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mandelbrot_escape_time: next-cycle check failed");

`endif

@@ rtl/core/mbe_pkg.sv @@
// Types and constants of the escape-time iteration ring.
// No dependencies; imported by every module of the block.
package mbe_pkg;

   localparam int COORD_W = 32;                 // Q5.F coordinates
   localparam int FRAC_W  = COORD_W - 5;
   localparam int MAG_W   = COORD_W - 3;        // holds magnitudes up to 2^(F+1)
   localparam int PROD_W  = 2 * MAG_W;
   localparam int SQ_W    = PROD_W - FRAC_W;    // truncated product
   localparam int SUM_W   = COORD_W + 2;        // update sums before saturation
   localparam int CNT_W   = 16;
   localparam int TAG_W   = 2;                  // three slots in flight, four tags

   localparam logic [CNT_W-1:0]   MAX_ITERS_RESET = CNT_W'(256);
   localparam logic [COORD_W-1:0] TWO_Q  = COORD_W'(2) << FRAC_W;
   localparam logic [SQ_W:0]      FOUR_Q = (SQ_W + 1)'(4) << FRAC_W;

   typedef struct packed {
      logic               valid;
      logic               done;
      logic [TAG_W-1:0]   tag;
      logic [COORD_W-1:0] c_real;
      logic [COORD_W-1:0] c_imag;
      logic [COORD_W-1:0] z_real;
      logic [COORD_W-1:0] z_imag;
      logic [CNT_W-1:0]   iter;
   } slot_type;

   typedef struct packed {
      slot_type           base;
      logic [MAG_W-1:0]   mag_real;
      logic [MAG_W-1:0]   mag_imag;
      logic               cross_neg;
   } mag_type;

   typedef struct packed {
      slot_type           base;
      logic [SQ_W-1:0]    sq_real;
      logic [SQ_W-1:0]    sq_imag;
      logic [SQ_W-1:0]    sq_cross;
      logic               cross_neg;
   } sq_type;

endpackage

@@ rtl/core/mbe_front.sv @@
// Ring stage 1: iteration limit check, large-z escape test, magnitudes.
// Depends on mbe_pkg and the assertion header.
`include "mandelbrot_escape_time_assert.svh"

module mbe_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mbe_pkg::CNT_W-1:0]   max_iters,
   input  mbe_pkg::slot_type           slot_in,
   output mbe_pkg::mag_type            mag_out
);
   import mbe_pkg::*;

   logic [COORD_W-1:0] abs_real;
   logic [COORD_W-1:0] abs_imag;
   logic               big;
   logic               limit;
   mag_type            mag_in;
   mag_type            mag_ff;

   always_comb begin
      abs_real = slot_in.z_real[COORD_W-1] ? (COORD_W'(0) - slot_in.z_real) : slot_in.z_real;
      abs_imag = slot_in.z_imag[COORD_W-1] ? (COORD_W'(0) - slot_in.z_imag) : slot_in.z_imag;
      big      = (abs_real > TWO_Q) || (abs_imag > TWO_Q);
      limit    = slot_in.iter >= max_iters;

      mag_in           = '0;
      mag_in.base      = slot_in;
      mag_in.base.done = slot_in.done | limit | big;
      // only meaningful when not big: then both fit MAG_W bits
      mag_in.mag_real  = abs_real[MAG_W-1:0];
      mag_in.mag_imag  = abs_imag[MAG_W-1:0];
      mag_in.cross_neg = slot_in.z_real[COORD_W-1] ^ slot_in.z_imag[COORD_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= '0;
      end else begin
         mag_ff <= mag_in;
      end
   end

   assign mag_out = mag_ff;

   `MBE_ASSERT_NEXT(a_limit_done, clock, reset, slot_in.valid && (slot_in.iter >= max_iters), mag_ff.base.valid && mag_ff.base.done)

endmodule

@@ rtl/core/mbe_square.sv @@
// Ring stage 2: the three magnitude products, truncated to Q.F.
// Depends on mbe_pkg.
module mbe_square (
   input  logic                clock,
   input  logic                reset,
   input  mbe_pkg::mag_type    mag_in,
   output mbe_pkg::sq_type     sq_out
);
   import mbe_pkg::*;

   logic [PROD_W-1:0] prod_rr;
   logic [PROD_W-1:0] prod_ii;
   logic [PROD_W-1:0] prod_ri;
   sq_type            sq_in;
   sq_type            sq_ff;

   always_comb begin
      prod_rr = PROD_W'(mag_in.mag_real) * PROD_W'(mag_in.mag_real);
      prod_ii = PROD_W'(mag_in.mag_imag) * PROD_W'(mag_in.mag_imag);
      prod_ri = PROD_W'(mag_in.mag_real) * PROD_W'(mag_in.mag_imag);

      sq_in           = '0;
      sq_in.base      = mag_in.base;
      sq_in.sq_real   = prod_rr[PROD_W-1:FRAC_W];
      sq_in.sq_imag   = prod_ii[PROD_W-1:FRAC_W];
      sq_in.sq_cross  = prod_ri[PROD_W-1:FRAC_W];
      sq_in.cross_neg = mag_in.cross_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff <= '0;
      end else begin
         sq_ff <= sq_in;
      end
   end

   assign sq_out = sq_ff;

endmodule

@@ rtl/core/mbe_update.sv @@
// Ring stage 3: |z|^2 escape test and the saturating z update.
// Depends on mbe_pkg and the assertion header.
`include "mandelbrot_escape_time_assert.svh"

module mbe_update (
   input  logic                clock,
   input  logic                reset,
   input  mbe_pkg::sq_type     sq_in,
   output mbe_pkg::slot_type   slot_out
);
   import mbe_pkg::*;

   function automatic logic [COORD_W-1:0] saturate(input logic [SUM_W-1:0] v);
      logic fits;
      fits = (v[SUM_W-1:COORD_W-1] == '0) || (v[SUM_W-1:COORD_W-1] == '1);
      if (fits) begin
         return v[COORD_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_W-1){1'b1}}};
      end
   endfunction

   logic [SQ_W:0]    sq_sum;
   logic             escaped;
   logic [SUM_W-1:0] diff;
   logic [SUM_W-1:0] cross2;
   logic [SUM_W-1:0] re_sum;
   logic [SUM_W-1:0] im_sum;
   slot_type         slot_in;
   slot_type         slot_ff;

   always_comb begin
      sq_sum  = {1'b0, sq_in.sq_real} + {1'b0, sq_in.sq_imag};
      escaped = sq_sum > FOUR_Q;

      diff   = SUM_W'(sq_in.sq_real) - SUM_W'(sq_in.sq_imag);
      // doubling after truncation, sign applied to the doubled magnitude
      cross2 = SUM_W'({sq_in.sq_cross, 1'b0});
      if (sq_in.cross_neg) begin
         cross2 = SUM_W'(0) - cross2;
      end
      re_sum = diff + {{(SUM_W-COORD_W){sq_in.base.c_real[COORD_W-1]}}, sq_in.base.c_real};
      im_sum = cross2 + {{(SUM_W-COORD_W){sq_in.base.c_imag[COORD_W-1]}}, sq_in.base.c_imag};

      slot_in = sq_in.base;
      if (!sq_in.base.done) begin
         if (escaped) begin
            slot_in.done = 1'b1;
         end else begin
            slot_in.z_real = saturate(re_sum);
            slot_in.z_imag = saturate(im_sum);
            slot_in.iter   = sq_in.base.iter + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

   `MBE_ASSERT_NEXT(a_done_holds, clock, reset, sq_in.base.valid && sq_in.base.done, slot_ff.done && (slot_ff.iter == $past(sq_in.base.iter)))

endmodule

@@ rtl/core/mandelbrot_escape_time.sv @@
// Escape-time counter for single complex points: a three-stage ring that
// iterates z = z*z + c. Depends on mbe_pkg, mbe_front, mbe_square, mbe_update
// and the assertion header.
//
// Each accepted point occupies one slot of a three-stage ring (limit and
// large-z check, squaring multipliers, escape test and saturating update);
// one iteration of a point takes one trip round the ring. Up to three
// points are in flight at once, so a new point can be taken while older
// ones still iterate, as long as a slot is free. Results leave in the order
// the points came in: a point that finishes early keeps circling until all
// older points have been delivered. csr_wdata sets the iteration limit
// (reset value 256); write it only while no transaction is in flight.
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mbe_pkg::CNT_W-1:0]   csr_wdata,     // max_iters
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [2*mbe_pkg::COORD_W-1:0] req_tdata,   // c_imag (high half), c_real (low half)
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [mbe_pkg::CNT_W-1:0]   rsp_tdata      // escape_count
);
   import mbe_pkg::*;

   logic [CNT_W-1:0] max_iters_ff;
   logic [TAG_W-1:0] in_tag_ff;
   logic [TAG_W-1:0] in_tag_in;
   logic [TAG_W-1:0] out_tag_ff;
   logic [TAG_W-1:0] out_tag_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CNT_W-1:0] rsp_count_ff;
   logic [CNT_W-1:0] rsp_count_in;

   slot_type entry_slot;
   mag_type  stage1;
   sq_type   stage2;
   slot_type stage3;

   logic out_free;
   logic retire;
   logic slot_free;
   logic accept;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_tready;
      retire    = stage3.valid && stage3.done && (stage3.tag == out_tag_ff) && out_free;
      slot_free = !stage3.valid || retire;
      accept    = req_tvalid && slot_free;

      entry_slot = stage3;
      if (accept) begin
         entry_slot.valid  = 1'b1;
         entry_slot.done   = 1'b0;
         entry_slot.tag    = in_tag_ff;
         entry_slot.c_real = req_tdata[COORD_W-1:0];
         entry_slot.c_imag = req_tdata[2*COORD_W-1:COORD_W];
         entry_slot.z_real = '0;
         entry_slot.z_imag = '0;
         entry_slot.iter   = '0;
      end else if (retire) begin
         entry_slot.valid = 1'b0;
      end

      in_tag_in  = accept ? in_tag_ff + TAG_W'(1) : in_tag_ff;
      out_tag_in = retire ? out_tag_ff + TAG_W'(1) : out_tag_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_count_in = rsp_count_ff;
      if (retire) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = stage3.iter;
      end
   end

   mbe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .max_iters (max_iters_ff),
      .slot_in   (entry_slot),
      .mag_out   (stage1)
   );

   mbe_square u_square (
      .clock  (clock),
      .reset  (reset),
      .mag_in (stage1),
      .sq_out (stage2)
   );

   mbe_update u_update (
      .clock    (clock),
      .reset    (reset),
      .sq_in    (stage2),
      .slot_out (stage3)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iters_ff <= MAX_ITERS_RESET;
         in_tag_ff    <= '0;
         out_tag_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            max_iters_ff <= csr_wdata;
         end
         in_tag_ff    <= in_tag_in;
         out_tag_ff   <= out_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
   end

   assign req_tready = slot_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;

   `MBE_ASSERT_NEXT(a_accept_enters, clock, reset, accept, stage1.base.valid && (stage1.base.tag == $past(in_tag_ff)) && (stage1.base.iter == '0))
   `MBE_ASSERT_NOW(a_tags_unique, clock, reset, stage1.base.valid && stage2.base.valid, stage1.base.tag != stage2.base.tag)

endmodule
